[sv/sfb_pkg.sv]
`default_nettype none
package sfb_pkg;

	localparam int DefFirTaps       = 8;
	localparam int DefAverageWindow = 4;
	localparam int DefSampleWidth   = 16;

	localparam int TapWidth      = 16;
	localparam int GainWidth     = 16;
	localparam int CfgWidth      = 32;
	localparam int CfgIndexWidth = 3;
	localparam int NumTapRegs    = 4;
	localparam int FracBits      = 15;
	localparam int RoundBias     = 1 << (FracBits - 1);

	typedef logic [CfgIndexWidth-1:0] cfg_index_t;
	typedef logic signed [TapWidth-1:0] tap_t;
	typedef logic [GainWidth-1:0] gain_t;

	// Register map.
	localparam cfg_index_t REG_TAPS_01  = 3'd0;
	localparam cfg_index_t REG_TAPS_23  = 3'd1;
	localparam cfg_index_t REG_TAPS_45  = 3'd2;
	localparam cfg_index_t REG_TAPS_67  = 3'd3;
	localparam cfg_index_t REG_FB_GAIN  = 3'd4;
	localparam cfg_index_t REG_IN_GAIN  = 3'd5;

	localparam logic [CfgWidth-1:0] RST_TAPS_01 = 32'd104792657;
	localparam logic [CfgWidth-1:0] RST_TAPS_23 = 32'd422383541;
	localparam logic [CfgWidth-1:0] RST_TAPS_45 = 32'd422386971;
	localparam logic [CfgWidth-1:0] RST_TAPS_67 = 32'd104796085;
	localparam gain_t RST_FB_GAIN = 16'd26214;
	localparam gain_t RST_IN_GAIN = 16'd6554;

	// Divisor of the moving average, as the number of samples minus one.
	typedef logic [1:0] div_code_t;
	localparam div_code_t DIV_BY_ONE   = 2'd0;
	localparam div_code_t DIV_BY_TWO   = 2'd1;
	localparam div_code_t DIV_BY_THREE = 2'd2;
	localparam div_code_t DIV_BY_FOUR  = 2'd3;

	typedef struct packed {
		logic adv_s2;
		logic adv_s3;
		logic restart_s1;
	} sfb_ctrl_t;

endpackage
`default_nettype wire

[sv/sfb_regs.sv]
`default_nettype none
module sfb_regs #(
	parameter int FIR_TAPS = sfb_pkg::DefFirTaps
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  sfb_pkg::cfg_index_t            cfg_index,
	input  logic [sfb_pkg::CfgWidth-1:0]   cfg_data,
	output sfb_pkg::tap_t                  taps [FIR_TAPS],
	output sfb_pkg::gain_t                 fb_gain,
	output sfb_pkg::gain_t                 in_gain
);
	import sfb_pkg::*;

	logic [CfgWidth-1:0] tap_pair_q [NumTapRegs];
	gain_t               fb_gain_q;
	gain_t               in_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_pair_q[0] <= RST_TAPS_01;
			tap_pair_q[1] <= RST_TAPS_23;
			tap_pair_q[2] <= RST_TAPS_45;
			tap_pair_q[3] <= RST_TAPS_67;
			fb_gain_q     <= RST_FB_GAIN;
			in_gain_q     <= RST_IN_GAIN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TAPS_01: tap_pair_q[0] <= cfg_data;
				REG_TAPS_23: tap_pair_q[1] <= cfg_data;
				REG_TAPS_45: tap_pair_q[2] <= cfg_data;
				REG_TAPS_67: tap_pair_q[3] <= cfg_data;
				REG_FB_GAIN: fb_gain_q     <= cfg_data[GainWidth-1:0];
				REG_IN_GAIN: in_gain_q     <= cfg_data[GainWidth-1:0];
				default: ;
			endcase
		end
	end

	// Even taps sit in the low half of each pair.
	for (genvar k = 0; k < FIR_TAPS; k++) begin : g_tap
		assign taps[k] = tap_t'(tap_pair_q[k / 2][(k % 2) * TapWidth +: TapWidth]);
	end

	assign fb_gain = fb_gain_q;
	assign in_gain = in_gain_q;

endmodule
`default_nettype wire

[sv/sfb_average.sv]
`default_nettype none
module sfb_average #(
	parameter int AVERAGE_WINDOW = sfb_pkg::DefAverageWindow,
	parameter int SAMPLE_WIDTH   = sfb_pkg::DefSampleWidth
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sfb_pkg::sfb_ctrl_t              ctrl,
	input  logic signed [SAMPLE_WIDTH-1:0]  sample_s1,
	output logic signed [SAMPLE_WIDTH-1:0]  average_out
);
	import sfb_pkg::*;

	localparam int HistDepth = AVERAGE_WINDOW - 1;
	localparam int FillWidth = $clog2(AVERAGE_WINDOW);
	localparam int SumWidth  = SAMPLE_WIDTH + 2;
	localparam int ProdWidth = 2 * SumWidth;
	localparam logic [SumWidth:0]   DivPow = {1'b1, {SumWidth{1'b0}}};
	localparam logic [SumWidth-1:0] Recip3 = SumWidth'(DivPow / 3);

	logic signed [SAMPLE_WIDTH-1:0] hist_q [HistDepth];
	logic [FillWidth-1:0]           fill_q;
	logic [FillWidth-1:0]           fill_eff;
	logic signed [SumWidth-1:0]     avg_sum;
	logic signed [SumWidth-1:0]     avg_sum_s2;
	div_code_t                      avg_div_s2;
	logic                           avg_neg;
	logic [SumWidth-1:0]            avg_mag;
	logic [ProdWidth-1:0]           recip_prod;
	logic [SumWidth-1:0]            quot3;
	logic [SumWidth-1:0]            rem3;
	logic [SumWidth-1:0]            quot3_fix;
	logic [SumWidth-1:0]            avg_quot;
	logic [SumWidth-1:0]            avg_res;
	logic signed [SAMPLE_WIDTH-1:0] average_s3;

	// A restart empties the window before this sample joins it.
	assign fill_eff = ctrl.restart_s1 ? '0 : fill_q;

	always_comb begin
		avg_sum = SumWidth'(sample_s1);
		for (int i = 0; i < HistDepth; i++) begin
			if (FillWidth'(i) < fill_eff) begin
				avg_sum = avg_sum + SumWidth'(hist_q[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (ctrl.adv_s2) begin
			fill_q <= (fill_eff == FillWidth'(HistDepth)) ? fill_eff : fill_eff + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv_s2) begin
			hist_q[0] <= sample_s1;
			for (int i = 1; i < HistDepth; i++) begin
				hist_q[i] <= hist_q[i-1];
			end
			avg_sum_s2 <= avg_sum;
			avg_div_s2 <= div_code_t'(fill_eff);
		end
	end

	// Divide the magnitude so the quotient truncates toward zero. The
	// reciprocal estimate is at most one low, so one correction suffices.
	always_comb begin
		avg_neg    = avg_sum_s2[SumWidth-1];
		avg_mag    = avg_neg ? (~avg_sum_s2 + 1'b1) : avg_sum_s2;
		recip_prod = ProdWidth'(avg_mag) * ProdWidth'(Recip3);
		quot3      = recip_prod[ProdWidth-1:SumWidth];
		rem3       = avg_mag - ((quot3 << 1) + quot3);
		quot3_fix  = (rem3 >= SumWidth'(3)) ? quot3 + 1'b1 : quot3;
		unique case (avg_div_s2)
			DIV_BY_ONE:   avg_quot = avg_mag;
			DIV_BY_TWO:   avg_quot = avg_mag >> 1;
			DIV_BY_THREE: avg_quot = quot3_fix;
			DIV_BY_FOUR:  avg_quot = avg_mag >> 2;
		endcase
		avg_res = avg_neg ? (~avg_quot + 1'b1) : avg_quot;
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv_s3) begin
			average_s3 <= avg_res[SAMPLE_WIDTH-1:0];
		end
	end

	assign average_out = average_s3;

endmodule
`default_nettype wire

[sv/sfb_fir.sv]
`default_nettype none
module sfb_fir #(
	parameter int FIR_TAPS     = sfb_pkg::DefFirTaps,
	parameter int SAMPLE_WIDTH = sfb_pkg::DefSampleWidth
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sfb_pkg::sfb_ctrl_t              ctrl,
	input  logic signed [SAMPLE_WIDTH-1:0]  sample_s1,
	input  sfb_pkg::tap_t                   taps [FIR_TAPS],
	output logic signed [SAMPLE_WIDTH-1:0]  fir_out
);
	import sfb_pkg::*;

	localparam int ProdWidth = SAMPLE_WIDTH + TapWidth;
	localparam int SumWidth  = ProdWidth + $clog2(FIR_TAPS);

	// The newest sample meets the first tap on its way in, so the
	// line holds one entry fewer than there are taps.
	logic signed [SAMPLE_WIDTH-1:0] delay_q [FIR_TAPS-1];
	logic signed [SAMPLE_WIDTH-1:0] tap_in  [FIR_TAPS];
	logic signed [ProdWidth-1:0]    prod_s2 [FIR_TAPS];
	logic signed [SumWidth-1:0]     fir_sum;
	logic signed [SumWidth-1:0]     fir_rnd;
	logic signed [SumWidth-1:0]     fir_shift;
	logic [SumWidth-SAMPLE_WIDTH:0] fir_hi;
	logic signed [SAMPLE_WIDTH-1:0] fir_sat;
	logic signed [SAMPLE_WIDTH-1:0] fir_s3;

	always_comb begin
		tap_in[0] = sample_s1;
		for (int k = 1; k < FIR_TAPS; k++) begin
			tap_in[k] = delay_q[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FIR_TAPS - 1; i++) begin
				delay_q[i] <= '0;
			end
		end else if (ctrl.adv_s2) begin
			delay_q[0] <= sample_s1;
			for (int i = 1; i < FIR_TAPS - 1; i++) begin
				delay_q[i] <= delay_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv_s2) begin
			for (int k = 0; k < FIR_TAPS; k++) begin
				prod_s2[k] <= ProdWidth'(taps[k]) * ProdWidth'(tap_in[k]);
			end
		end
	end

	// Round half up, then clamp to the sample range.
	always_comb begin
		fir_sum = '0;
		for (int k = 0; k < FIR_TAPS; k++) begin
			fir_sum = fir_sum + SumWidth'(prod_s2[k]);
		end
		fir_rnd   = fir_sum + SumWidth'(RoundBias);
		fir_shift = fir_rnd >>> FracBits;
		fir_hi    = fir_shift[SumWidth-1:SAMPLE_WIDTH-1];
		if ((&fir_hi) || !(|fir_hi)) begin
			fir_sat = fir_shift[SAMPLE_WIDTH-1:0];
		end else if (fir_hi[SumWidth-SAMPLE_WIDTH]) begin
			fir_sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
		end else begin
			fir_sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv_s3) begin
			fir_s3 <= fir_sat;
		end
	end

	assign fir_out = fir_s3;

endmodule
`default_nettype wire

[sv/sfb_iir.sv]
`default_nettype none
module sfb_iir #(
	parameter int SAMPLE_WIDTH = sfb_pkg::DefSampleWidth
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sfb_pkg::sfb_ctrl_t              ctrl,
	input  logic signed [SAMPLE_WIDTH-1:0]  sample_s1,
	input  sfb_pkg::gain_t                  fb_gain,
	input  sfb_pkg::gain_t                  in_gain,
	output logic signed [SAMPLE_WIDTH-1:0]  iir_out
);
	import sfb_pkg::*;

	localparam int ProdWidth = SAMPLE_WIDTH + GainWidth + 1;
	localparam int SumWidth  = ProdWidth + 1;

	logic signed [GainWidth:0]      fb_gain_s;
	logic signed [GainWidth:0]      in_gain_s;
	logic                           seeded_q;
	logic                           seed_s2;
	logic signed [SAMPLE_WIDTH-1:0] x_s2;
	logic signed [ProdWidth-1:0]    bx_s2;
	logic signed [ProdWidth-1:0]    iir_ay;
	logic signed [SumWidth-1:0]     iir_rnd;
	logic signed [SumWidth-1:0]     iir_shift;
	logic [SumWidth-SAMPLE_WIDTH:0] iir_hi;
	logic signed [SAMPLE_WIDTH-1:0] iir_sat;
	logic signed [SAMPLE_WIDTH-1:0] iir_q;

	assign fb_gain_s = $signed({1'b0, fb_gain});
	assign in_gain_s = $signed({1'b0, in_gain});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q <= 1'b0;
		end else if (ctrl.adv_s2) begin
			seeded_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv_s2) begin
			seed_s2 <= ctrl.restart_s1 || !seeded_q;
			x_s2    <= sample_s1;
			bx_s2   <= ProdWidth'(in_gain_s) * ProdWidth'(sample_s1);
		end
	end

	// The feedback product closes the recursion within this stage.
	always_comb begin
		iir_ay    = ProdWidth'(fb_gain_s) * ProdWidth'(iir_q);
		iir_rnd   = SumWidth'(iir_ay) + SumWidth'(bx_s2) + SumWidth'(RoundBias);
		iir_shift = iir_rnd >>> FracBits;
		iir_hi    = iir_shift[SumWidth-1:SAMPLE_WIDTH-1];
		if ((&iir_hi) || !(|iir_hi)) begin
			iir_sat = iir_shift[SAMPLE_WIDTH-1:0];
		end else if (iir_hi[SumWidth-SAMPLE_WIDTH]) begin
			iir_sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
		end else begin
			iir_sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iir_q <= '0;
		end else if (ctrl.adv_s3) begin
			iir_q <= seed_s2 ? x_s2 : iir_sat;
		end
	end

	assign iir_out = iir_q;

endmodule
`default_nettype wire

[sv/sample_filter_bank.sv]
// Channel | Direction | Carries
// s_*     | in        | one sensor sample per item, restart flag in tuser
// m_*     | out       | average, FIR and IIR results of that sample
// cfg_*   | in        | register writes, taken whenever cfg_we is high
//
// One item per cycle while m_tready is high; items pass s1, s2, then s3.
// The rate is set by the IIR feedback, whose multiply, round and clamp close
// in the last stage every cycle.
// Reset clears the stage valids, the FIR delay line, the average fill count,
// the IIR value and seed flag, and loads the register reset values.
// With m_tready low the result holds and up to three items queue in the
// stages before s_tready drops.
`default_nettype none
module sample_filter_bank #(
	parameter int FIR_TAPS       = sfb_pkg::DefFirTaps,
	parameter int AVERAGE_WINDOW = sfb_pkg::DefAverageWindow,
	parameter int SAMPLE_WIDTH   = sfb_pkg::DefSampleWidth
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       s_tvalid,
	output logic                                       s_tready,
	// sample
	input  logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0]  s_tdata,
	// restart
	input  logic [0:0]                                 s_tuser,
	output logic                                       m_tvalid,
	input  logic                                       m_tready,
	// average_out, fir_out, iir_out
	output logic [((3 * SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
	input  logic                                       cfg_we,
	input  sfb_pkg::cfg_index_t                        cfg_index,
	input  logic [sfb_pkg::CfgWidth-1:0]               cfg_data
);
	import sfb_pkg::*;

	localparam int OutWidth = ((3 * SAMPLE_WIDTH + 7) / 8) * 8;

	logic                           valid_s1;
	logic                           valid_s2;
	logic                           valid_s3;
	logic                           accept;
	logic                           adv_s2;
	logic                           adv_s3;
	logic signed [SAMPLE_WIDTH-1:0] sample_s1;
	logic                           restart_s1;
	sfb_ctrl_t                      ctrl;
	tap_t                           taps [FIR_TAPS];
	gain_t                          fb_gain;
	gain_t                          in_gain;
	logic signed [SAMPLE_WIDTH-1:0] average_out;
	logic signed [SAMPLE_WIDTH-1:0] fir_out;
	logic signed [SAMPLE_WIDTH-1:0] iir_out;

	assign adv_s3   = valid_s2 && (!valid_s3 || m_tready);
	assign adv_s2   = valid_s1 && (!valid_s2 || adv_s3);
	assign s_tready = !valid_s1 || adv_s2;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !adv_s2);
			valid_s2 <= adv_s2 || (valid_s2 && !adv_s3);
			valid_s3 <= adv_s3 || (valid_s3 && !m_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1  <= s_tdata[SAMPLE_WIDTH-1:0];
			restart_s1 <= s_tuser[0];
		end
	end

	assign ctrl.adv_s2     = adv_s2;
	assign ctrl.adv_s3     = adv_s3;
	assign ctrl.restart_s1 = restart_s1;

	sfb_regs #(
		.FIR_TAPS (FIR_TAPS)
	) u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.taps      (taps),
		.fb_gain   (fb_gain),
		.in_gain   (in_gain)
	);

	sfb_average #(
		.AVERAGE_WINDOW (AVERAGE_WINDOW),
		.SAMPLE_WIDTH   (SAMPLE_WIDTH)
	) u_average (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.sample_s1   (sample_s1),
		.average_out (average_out)
	);

	sfb_fir #(
		.FIR_TAPS     (FIR_TAPS),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_fir (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.sample_s1 (sample_s1),
		.taps      (taps),
		.fir_out   (fir_out)
	);

	sfb_iir #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_iir (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.sample_s1 (sample_s1),
		.fb_gain   (fb_gain),
		.in_gain   (in_gain),
		.iir_out   (iir_out)
	);

	assign m_tvalid = valid_s3;
	assign m_tdata  = OutWidth'({iir_out, fir_out, average_out});

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted item did not enter the input stage");

	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !valid_s2 |=> valid_s2)
		else $error("item stuck in the input stage with the next stage free");

	a_s2_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !valid_s3 |=> m_tvalid)
		else $error("item stuck in stage two with the result register free");

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && valid_s3 && !m_tready |-> !s_tready)
		else $error("input taken while every stage is full and stalled");

endmodule
`default_nettype wire

[tb/sample_filter_bank_test.sv]
`timescale 1ns / 1ps
module sample_filter_bank_test;
	import sfb_pkg::*;

	localparam int PIPE_LATENCY = 3;
	localparam int STALL_LIMIT  = 2000;
	localparam int SAMPLE_MAX   = 32767;
	localparam int SAMPLE_MIN   = -32768;

	// Indexes past the register map; writes to them must change nothing.
	localparam cfg_index_t REG_SPARE_6 = 3'd6;
	localparam cfg_index_t REG_SPARE_7 = 3'd7;

	typedef struct {
		logic signed [15:0] sample;
		logic               restart;
	} sensor_item_t;

	// Same layout as m_tdata: average in the low bits, IIR in the high bits.
	typedef struct packed {
		logic signed [15:0] iir;
		logic signed [15:0] fir;
		logic signed [15:0] avg;
	} filter_result_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata   = '0;  // sample
	logic [0:0]  s_tuser   = '0;  // restart
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [47:0] m_tdata;         // average_out, fir_out, iir_out
	logic        cfg_we    = 1'b0;
	cfg_index_t  cfg_index = '0;
	logic [31:0] cfg_data  = '0;

	sample_filter_bank u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Filter state as the block should hold it.
	logic [31:0]        tap_regs [4] = '{RST_TAPS_01, RST_TAPS_23, RST_TAPS_45, RST_TAPS_67};
	logic [15:0]        fb_gain      = RST_FB_GAIN;
	logic [15:0]        in_gain      = RST_IN_GAIN;
	logic signed [15:0] avg_hist [3] = '{default: '0};
	int                 avg_fill     = 0;
	logic signed [15:0] fir_line [8] = '{default: '0};
	logic signed [15:0] iir_val      = '0;
	logic               iir_seeded   = 1'b0;

	sensor_item_t   pending_samples[$];
	filter_result_t expected_results[$];

	logic quiet_tail    = 1'b0;
	int   send_gap      = 0;
	int   sink_stall    = 0;
	int   stuck_cycles  = 0;
	int   mismatches    = 0;
	int   samples_sent  = 0;
	int   restarts_sent = 0;
	int   results_seen  = 0;
	int   settings_used = 1;

	// Round half toward plus infinity from Q.15, then clamp to 16 bits.
	function automatic logic signed [15:0] round_clamp(input longint acc);
		longint q;
		q = (acc + 16384) >>> 15;
		if (q > SAMPLE_MAX)
			return 16'sh7FFF;
		if (q < SAMPLE_MIN)
			return 16'sh8000;
		return 16'(q);
	endfunction

	function automatic filter_result_t filter_step(input sensor_item_t item);
		filter_result_t     res;
		longint             acc;
		logic signed [15:0] tap;
		int                 k;
		if (item.restart) begin
			avg_fill   = 0;
			iir_seeded = 1'b0;
		end

		acc = item.sample;
		for (k = 0; k < avg_fill; k++)
			acc += avg_hist[k];
		// Signed division truncates toward zero.
		res.avg = 16'(acc / (avg_fill + 1));
		avg_hist[2] = avg_hist[1];
		avg_hist[1] = avg_hist[0];
		avg_hist[0] = item.sample;
		if (avg_fill < 3)
			avg_fill++;

		for (k = 7; k > 0; k--)
			fir_line[k] = fir_line[k - 1];
		fir_line[0] = item.sample;
		acc = 0;
		for (k = 0; k < 8; k++) begin
			tap = tap_regs[k >> 1][(k & 1) * 16 +: 16];
			acc += longint'(tap) * longint'(fir_line[k]);
		end
		res.fir = round_clamp(acc);

		if (!iir_seeded) begin
			res.iir    = item.sample;
			iir_seeded = 1'b1;
		end else begin
			res.iir = round_clamp(longint'(fb_gain) * longint'(iir_val)
				+ longint'(in_gain) * longint'(item.sample));
		end
		iir_val = res.iir;
		return res;
	endfunction

	always @(posedge clk) begin : driver
		sensor_item_t item;
		logic         next_valid;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				item.sample  = s_tdata;
				item.restart = s_tuser[0];
				expected_results.push_back(filter_step(item));
				samples_sent++;
				if (item.restart)
					restarts_sent++;
			end
			if (!s_tvalid || s_tready) begin
				next_valid = 1'b0;
				if (send_gap != 0) begin
					send_gap--;
				end else if (pending_samples.size() != 0) begin
					item       = pending_samples.pop_front();
					next_valid = 1'b1;
					s_tdata   <= item.sample;
					s_tuser   <= item.restart;
					if (!quiet_tail && $urandom_range(0, 5) == 0)
						send_gap = $urandom_range(1, 3);
				end
				s_tvalid <= next_valid;
			end
		end
	end

	always @(posedge clk) begin : monitor
		filter_result_t got;
		filter_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				results_seen++;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: avg %0d fir %0d iir %0d",
							got.avg, got.fir, got.iir);
				end else begin
					want = expected_results.pop_front();
					if (got.avg !== want.avg || got.fir !== want.fir || got.iir !== want.iir) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result %0d: expected avg %0d fir %0d iir %0d, got avg %0d fir %0d iir %0d",
								results_seen, want.avg, want.fir, want.iir,
								got.avg, got.fir, got.iir);
					end
				end
			end
			if (sink_stall != 0) begin
				sink_stall--;
				m_tready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
				sink_stall = $urandom_range(0, 2);
				m_tready  <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles == STALL_LIMIT) begin
			$display("no item moved for %0d cycles", STALL_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	task automatic push_item(input logic signed [15:0] sample, input logic restart);
		sensor_item_t item;
		item.sample  = sample;
		item.restart = restart;
		pending_samples.push_back(item);
	endtask

	task automatic push_random(input int count);
		logic signed [15:0] s;
		repeat (count) begin
			case ($urandom_range(0, 9))
				0:       s = 16'sh7FFF;
				1:       s = 16'sh8000;
				2, 3:    s = 16'($urandom_range(0, 200) - 100);
				default: s = 16'($urandom());
			endcase
			push_item(s, $urandom_range(0, 11) == 0);
			// A constant run lets the IIR settle toward the input.
			if ($urandom_range(0, 19) == 0)
				repeat (5) push_item(s, 1'b0);
		end
	endtask

	// Full-scale runs of both signs, starting with a restart.
	task automatic push_extremes();
		push_item(16'sh7FFF, 1'b1);
		repeat (8) push_item(16'sh7FFF, 1'b0);
		repeat (9) push_item(16'sh8000, 1'b0);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [31:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TAPS_01, REG_TAPS_23, REG_TAPS_45, REG_TAPS_67: tap_regs[idx[1:0]] = value;
			REG_FB_GAIN: fb_gain = value[15:0];
			REG_IN_GAIN: in_gain = value[15:0];
			default: ;
		endcase
	endtask

	task automatic write_setting(input logic [31:0] t01, input logic [31:0] t23,
		input logic [31:0] t45, input logic [31:0] t67,
		input logic [15:0] fb, input logic [15:0] gin);
		write_reg(REG_TAPS_01, t01);
		write_reg(REG_TAPS_23, t23);
		write_reg(REG_TAPS_45, t45);
		write_reg(REG_TAPS_67, t67);
		// Upper bits of the gain writes are junk the block must drop.
		write_reg(REG_FB_GAIN, {16'($urandom()), fb});
		write_reg(REG_IN_GAIN, {16'($urandom()), gin});
		write_reg(REG_SPARE_6, $urandom());
		write_reg(REG_SPARE_7, $urandom());
		settings_used++;
	endtask

	task automatic drain();
		while (pending_samples.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 1) @(posedge clk);
	endtask

	initial begin : stimulus
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Warm-up of the average, truncation of negative means, seeding and
		// extremes, all under the reset register values.
		push_item(16'sd100, 1'b1);
		push_item(16'sd0, 1'b0);
		push_item(-16'sd1, 1'b1);
		push_item(-16'sd2, 1'b0);
		push_item(-16'sd4, 1'b0);
		push_item(-16'sd8, 1'b0);
		push_item(-16'sd16, 1'b0);
		push_item(16'sh7FFF, 1'b1);
		repeat (3) push_item(16'sh7FFF, 1'b0);
		repeat (4) push_item(16'sh8000, 1'b0);
		push_item(16'sh8000, 1'b1);
		push_item(16'sd1, 1'b0);
		push_item(-16'sd1, 1'b0);
		push_item(16'sd0, 1'b1);
		push_item(16'sd3, 1'b0);
		push_random(100);
		drain();

		// Largest positive taps with unity gains: the FIR saturates.
		write_setting(32'h7FFF7FFF, 32'h7FFF7FFF, 32'h7FFF7FFF, 32'h7FFF7FFF,
			16'd32768, 16'd32768);
		push_extremes();
		push_random(100);
		drain();

		// Most negative taps and zero gains.
		write_setting(32'h80008000, 32'h80008000, 32'h80008000, 32'h80008000,
			16'd0, 16'd0);
		push_extremes();
		push_random(100);
		drain();

		// Random taps with gains just under two.
		write_setting($urandom(), $urandom(), $urandom(), $urandom(), 16'hFFFF, 16'hFFFF);
		push_extremes();
		push_random(100);
		drain();

		// Random in-range gains, no idling on either side.
		write_setting($urandom(), $urandom(), $urandom(), $urandom(),
			16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)));
		quiet_tail = 1'b1;
		push_random(120);
		drain();

		$display("Sent %0d samples (%0d with restart) across %0d register settings.",
			samples_sent, restarts_sent, settings_used);
		$display("Checked %0d results, %0d mismatches.", results_seen, mismatches);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
